[rtl/bcc_pkg.sv]
// Shared types, status codes and parity-check helpers for the (16,8) block code codec.
package bcc_pkg;

   // Reset value of the parity matrix register.
   localparam logic [63:0] PARITY_MATRIX_RESET = 64'hE77B95E956AACCF0;

   // Result status codes.
   localparam logic [1:0] STAT_CLEAN  = 2'd0;
   localparam logic [1:0] STAT_SINGLE = 2'd1;
   localparam logic [1:0] STAT_DOUBLE = 2'd2;
   localparam logic [1:0] STAT_UNCORR = 2'd3;

   // Sixteen columns of H, each eight bits wide (bit k is row k).
   typedef logic [15:0][7:0] bcc_cols_type;

   // Stage 1: word and syndrome (syndrome is zero for an encode beat).
   typedef struct packed {
      logic        vld;
      logic [15:0] word;
      logic [7:0]  syn;
   } bcc_s1_type;

   // Stage 2: compare results for every column pair and every single column.
   typedef struct packed {
      logic              vld;
      logic [15:0]       word;
      logic              syn_nz;
      logic [15:0][15:0] pair_hit;
      logic [15:0]       single_hit;
   } bcc_s2_type;

   // Stage 3: first matching partner per first column, first matching single.
   typedef struct packed {
      logic             vld;
      logic [15:0]      word;
      logic             syn_nz;
      logic [15:0]      row_hit;
      logic [15:0][3:0] row_j;
      logic             single_any;
      logic [3:0]       single_pos;
   } bcc_s3_type;

   // Output beat.
   typedef struct packed {
      logic        vld;
      logic [7:0]  data_out;
      logic [15:0] codeword_out;
      logic [1:0]  status;
      logic [3:0]  pos1;
      logic [3:0]  pos2;
   } bcc_rsp_type;

   // Build the columns of H = [P | I8] from the parity matrix register.
   function automatic bcc_cols_type h_columns(input logic [63:0] m);
      bcc_cols_type cols;
      for (int c = 0; c < 8; c++) begin
         for (int k = 0; k < 8; k++) begin
            cols[c][k] = m[8*k + 7 - c];
         end
      end
      for (int c = 8; c < 16; c++) begin
         cols[c] = 8'(1) << (c - 8);
      end
      return cols;
   endfunction

endpackage

[rtl/bcc_syn.sv]
// First pipeline stage: parity generation for encode and syndrome for decode.
module bcc_syn (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                mode,
   input  logic [7:0]          data_byte,
   input  logic [15:0]         codeword,
   input  logic [63:0]         parity_matrix,
   output bcc_pkg::bcc_s1_type s1
);

   bcc_pkg::bcc_s1_type s1_ff;
   bcc_pkg::bcc_s1_type s1_in;

   // Each row of P is dotted with the data byte; decode adds the received parity.
   always_comb begin
      logic [7:0] dat;
      logic [7:0] par;
      logic [7:0] syn;
      dat = mode ? codeword[15:8] : data_byte;
      for (int k = 0; k < 8; k++) begin
         par[7 - k] = ^(dat & parity_matrix[8*k +: 8]);
         syn[k]     = par[7 - k] ^ codeword[7 - k];
      end
      s1_in.vld = accept;
      if (mode) begin
         s1_in.word = codeword;
         s1_in.syn  = syn;
      end else begin
         s1_in.word = {data_byte, par};
         s1_in.syn  = '0;
      end
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else begin
         s1_ff <= s1_in;
      end
   end

   assign s1 = s1_ff;

endmodule

[rtl/bcc_search.sv]
// Second and third pipeline stages: column compares, then first match per row.
module bcc_search (
   input  logic                clock,
   input  logic                reset,
   input  logic [63:0]         parity_matrix,
   input  bcc_pkg::bcc_s1_type s1,
   output bcc_pkg::bcc_s3_type s3
);

   bcc_pkg::bcc_s2_type  s2_ff;
   bcc_pkg::bcc_s2_type  s2_in;
   bcc_pkg::bcc_s3_type  s3_ff;
   bcc_pkg::bcc_s3_type  s3_in;
   bcc_pkg::bcc_cols_type cols;

   assign cols = bcc_pkg::h_columns(parity_matrix);

   // Compare the syndrome against every pair i<j and every single column in parallel.
   always_comb begin
      s2_in.vld    = s1.vld;
      s2_in.word   = s1.word;
      s2_in.syn_nz = |s1.syn;
      for (int i = 0; i < 16; i++) begin
         s2_in.single_hit[i] = (cols[i] == s1.syn);
         for (int j = 0; j < 16; j++) begin
            s2_in.pair_hit[i][j] = (j > i) && ((cols[i] ^ cols[j]) == s1.syn);
         end
      end
   end

   // Priority pick of the lowest partner j for each i, and of the lowest single.
   always_comb begin
      s3_in.vld        = s2_ff.vld;
      s3_in.word       = s2_ff.word;
      s3_in.syn_nz     = s2_ff.syn_nz;
      s3_in.single_any = |s2_ff.single_hit;
      s3_in.single_pos = '0;
      for (int c = 15; c >= 0; c--) begin
         if (s2_ff.single_hit[c]) begin
            s3_in.single_pos = 4'(c);
         end
      end
      for (int i = 0; i < 16; i++) begin
         s3_in.row_hit[i] = |s2_ff.pair_hit[i];
         s3_in.row_j[i]   = '0;
         for (int j = 15; j >= 0; j--) begin
            if (s2_ff.pair_hit[i][j]) begin
               s3_in.row_j[i] = 4'(j);
            end
         end
      end
   end

   // Stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff <= '0;
         s3_ff <= '0;
      end else begin
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   assign s3 = s3_ff;

endmodule

[rtl/bcc_fix.sv]
// Last pipeline stage: choose the correction, flip the bits and register the result.
module bcc_fix (
   input  logic                 clock,
   input  logic                 reset,
   input  bcc_pkg::bcc_s3_type  s3,
   output bcc_pkg::bcc_rsp_type rsp
);

   bcc_pkg::bcc_rsp_type rsp_ff;
   bcc_pkg::bcc_rsp_type rsp_in;

   // A pair match wins over a single match; no match leaves the word as received.
   always_comb begin
      logic [3:0]  sel;
      logic [15:0] word;
      sel = '0;
      for (int i = 15; i >= 0; i--) begin
         if (s3.row_hit[i]) begin
            sel = 4'(i);
         end
      end
      word          = s3.word;
      rsp_in.vld    = s3.vld;
      rsp_in.status = bcc_pkg::STAT_CLEAN;
      rsp_in.pos1   = '0;
      rsp_in.pos2   = '0;
      if (s3.syn_nz) begin
         if (|s3.row_hit) begin
            word          = word ^ (16'h8000 >> sel) ^ (16'h8000 >> s3.row_j[sel]);
            rsp_in.status = bcc_pkg::STAT_DOUBLE;
            rsp_in.pos1   = sel;
            rsp_in.pos2   = s3.row_j[sel];
         end else if (s3.single_any) begin
            word          = word ^ (16'h8000 >> s3.single_pos);
            rsp_in.status = bcc_pkg::STAT_SINGLE;
            rsp_in.pos1   = s3.single_pos;
         end else begin
            rsp_in.status = bcc_pkg::STAT_UNCORR;
         end
      end
      rsp_in.codeword_out = word;
      rsp_in.data_out     = word[15:8];
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff <= '0;
      end else begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

[rtl/block_code_16_8_codec_core.sv]
// Top level of the (16,8) block code codec: parity matrix register and four-stage pipeline.
// A beat's result reaches rsp_valid after the syndrome, compare, pick and output registers.
// Throughput: one beat per cycle; the four register stages (syndrome, column compares,
// per-row priority pick, final selection and flip) each take a new beat every cycle.
// busy is high only during reset; the result side cannot stall, so nothing holds the pipe.
// Reset clears all valid bits and loads the parity matrix with its default value.
module block_code_16_8_codec_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_codeword,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_parity_matrix,
   output logic        rsp_valid,
   output logic [7:0]  rsp_data_out,
   output logic [15:0] rsp_codeword_out,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_first_error_position,
   output logic [3:0]  rsp_second_error_position
);

   logic [63:0]          parity_matrix_ff;
   logic [63:0]          parity_matrix_in;
   logic                 accept;
   bcc_pkg::bcc_s1_type  s1;
   bcc_pkg::bcc_s3_type  s3;
   bcc_pkg::bcc_rsp_type rsp;

   // Handshakes.
   assign busy      = reset;
   assign csr_ready = !reset;
   assign accept    = start && !busy;

   // Parity matrix register, written by a configuration beat.
   assign parity_matrix_in = (csr_valid && csr_ready) ? csr_parity_matrix : parity_matrix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_matrix_ff <= bcc_pkg::PARITY_MATRIX_RESET;
      end else begin
         parity_matrix_ff <= parity_matrix_in;
      end
   end

   bcc_syn u_syn (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .mode          (req_mode),
      .data_byte     (req_data_byte),
      .codeword      (req_codeword),
      .parity_matrix (parity_matrix_ff),
      .s1            (s1)
   );

   bcc_search u_search (
      .clock         (clock),
      .reset         (reset),
      .parity_matrix (parity_matrix_ff),
      .s1            (s1),
      .s3            (s3)
   );

   bcc_fix u_fix (
      .clock (clock),
      .reset (reset),
      .s3    (s3),
      .rsp   (rsp)
   );

   // Result beat.
   assign rsp_valid                 = rsp.vld;
   assign rsp_data_out              = rsp.data_out;
   assign rsp_codeword_out          = rsp.codeword_out;
   assign rsp_status                = rsp.status;
   assign rsp_first_error_position  = rsp.pos1;
   assign rsp_second_error_position = rsp.pos2;

endmodule
